// File: rtl/core/http_header_byte_parser_macros.svh
// Assertion macros shared by the HTTP header byte parser RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef HTTP_HEADER_BYTE_PARSER_MACROS_SVH
`define HTTP_HEADER_BYTE_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HHBP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HHBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/hhbp_pkg.sv
// Shared types, codes and constants for the HTTP header byte parser.
// No dependencies; imported by every module of the block.
package hhbp_pkg;

  localparam int NAME_W  = 10;
  localparam int VALUE_W = 13;
  localparam int BYTE_W  = 8;
  localparam int STATE_W = 3;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam int NAME_LIMIT_MAX_DEF  = 1023;
  localparam int VALUE_LIMIT_MAX_DEF = 8191;

  localparam logic [NAME_W-1:0]  NAME_LIMIT_RST  = NAME_W'(256);
  localparam logic [VALUE_W-1:0] VALUE_LIMIT_RST = VALUE_W'(4096);

  // Register indexes, taken from paddr[2].
  localparam logic REG_NAME_LIMIT  = 1'b0;
  localparam logic REG_VALUE_LIMIT = 1'b1;

  // Input command codes.
  localparam logic CMD_DATA    = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  // Parser states.
  localparam logic [STATE_W-1:0] ST_LINE_START  = 3'd0;
  localparam logic [STATE_W-1:0] ST_CONT_WS     = 3'd1;
  localparam logic [STATE_W-1:0] ST_NAME        = 3'd2;
  localparam logic [STATE_W-1:0] ST_SPACE       = 3'd3;
  localparam logic [STATE_W-1:0] ST_VALUE_START = 3'd4;
  localparam logic [STATE_W-1:0] ST_VALUE       = 3'd5;
  localparam logic [STATE_W-1:0] ST_LF_ONE      = 3'd6;
  localparam logic [STATE_W-1:0] ST_LF_TWO      = 3'd7;

  // Result status codes.
  localparam logic [1:0] RES_MORE = 2'd0;
  localparam logic [1:0] RES_OK   = 2'd1;
  localparam logic [1:0] RES_FAIL = 2'd2;

  // Characters of interest.
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [BYTE_W-1:0] CH_CTL_TOP = 8'h1F;

  typedef struct packed {
    logic [NAME_W-1:0]  name_lim;
    logic [VALUE_W-1:0] value_lim;
  } limits_t;

  // Field order matches out_tuser from bit 0 up, then the echoed byte.
  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic              header_done;
    logic              value_first;
    logic              value_char;
    logic              name_first;
    logic              name_char;
    logic [1:0]        status;
  } result_t;

  function automatic logic is_ctl(input logic [BYTE_W-1:0] b);
    return (b <= CH_CTL_TOP) || (b == CH_DEL);
  endfunction

endpackage

// File: rtl/core/hhbp_cfg_regs.sv
// APB register bank holding the name and value length limits.
// Depends on hhbp_pkg; delivers the limits clamped to the build-time maxima.
module hhbp_cfg_regs import hhbp_pkg::*; #(
  parameter int NAME_LIMIT_MAX  = NAME_LIMIT_MAX_DEF,
  parameter int VALUE_LIMIT_MAX = VALUE_LIMIT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output limits_t           limits
);

  localparam int NAME_REG_MAX  = (1 << NAME_W) - 1;
  localparam int VALUE_REG_MAX = (1 << VALUE_W) - 1;
  localparam logic [NAME_W-1:0] NAME_CAP =
    NAME_W'((NAME_LIMIT_MAX > NAME_REG_MAX) ? NAME_REG_MAX : NAME_LIMIT_MAX);
  localparam logic [VALUE_W-1:0] VALUE_CAP =
    VALUE_W'((VALUE_LIMIT_MAX > VALUE_REG_MAX) ? VALUE_REG_MAX : VALUE_LIMIT_MAX);

  logic [NAME_W-1:0]  name_limit_r;
  logic [VALUE_W-1:0] value_limit_r;
  logic               wr_en;
  logic               reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r  <= NAME_LIMIT_RST;
      value_limit_r <= VALUE_LIMIT_RST;
    end else if (wr_en) begin
      case (reg_sel)
        REG_NAME_LIMIT:  name_limit_r  <= pwdata[NAME_W-1:0];
        REG_VALUE_LIMIT: value_limit_r <= pwdata[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_NAME_LIMIT:  prdata = CFG_DW'(name_limit_r);
      REG_VALUE_LIMIT: prdata = CFG_DW'(value_limit_r);
      default:         prdata = '0;
    endcase
  end

  assign limits.name_lim  = (name_limit_r > NAME_CAP) ? NAME_CAP : name_limit_r;
  assign limits.value_lim = (value_limit_r > VALUE_CAP) ? VALUE_CAP : value_limit_r;

endmodule

// File: rtl/core/hhbp_parser.sv
// Input register, parse state, length counters and the per-byte decision logic.
// Depends on hhbp_pkg and the shared assertion macro header.
`include "http_header_byte_parser_macros.svh"

module hhbp_parser import hhbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  limits_t           limits,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  input  logic [BYTE_W-1:0] in_byte,
  output logic              res_valid,
  input  logic              res_ready,
  output result_t           res
);

  logic               valid_r;
  logic               cmd_r;
  logic [BYTE_W-1:0]  byte_r;
  logic [STATE_W-1:0] state_r, state_nxt;
  logic [NAME_W-1:0]  name_len_r, name_len_nxt;
  logic [VALUE_W-1:0] value_len_r, value_len_nxt;
  logic               advance;
  logic               is_ws;
  logic               plain;
  logic               ctl;

  assign advance   = valid_r && res_ready;
  assign in_ready  = !valid_r || res_ready;
  assign res_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_r  <= in_cmd;
      byte_r <= in_byte;
    end
  end

  assign is_ws = (byte_r == CH_SPACE) || (byte_r == CH_TAB);
  assign plain = !byte_r[BYTE_W-1];
  assign ctl   = is_ctl(byte_r);

  // A failing byte leaves state and lengths untouched, so defaults hold them.
  always_comb begin
    state_nxt       = state_r;
    name_len_nxt    = name_len_r;
    value_len_nxt   = value_len_r;
    res             = '0;
    res.status      = RES_FAIL;
    res.byte_out    = byte_r;
    if (cmd_r == CMD_RESTART) begin
      state_nxt     = ST_LINE_START;
      name_len_nxt  = '0;
      value_len_nxt = '0;
      res.status    = RES_MORE;
    end else begin
      case (state_r)
        ST_LINE_START: begin
          if (byte_r == CH_CR) begin
            state_nxt  = ST_LF_TWO;
            res.status = RES_MORE;
          end else if (is_ws) begin
            // Folding is only legal once some header name has been seen.
            if (name_len_r != '0) begin
              state_nxt  = ST_CONT_WS;
              res.status = RES_MORE;
            end
          end else if (plain) begin
            name_len_nxt   = NAME_W'(1);
            state_nxt      = ST_NAME;
            res.name_char  = 1'b1;
            res.name_first = 1'b1;
            res.status     = RES_MORE;
          end
        end
        ST_CONT_WS: begin
          if (byte_r == CH_CR) begin
            state_nxt  = ST_LF_ONE;
            res.status = RES_MORE;
          end else if (is_ws) begin
            res.status = RES_MORE;
          end else if (!ctl && (value_len_r < limits.value_lim)) begin
            value_len_nxt  = value_len_r + 1'b1;
            state_nxt      = ST_VALUE;
            res.value_char = 1'b1;
            res.status     = RES_MORE;
          end
        end
        ST_NAME: begin
          if (byte_r == CH_COLON) begin
            state_nxt  = ST_SPACE;
            res.status = RES_MORE;
          end else if (plain && (name_len_r < limits.name_lim)) begin
            name_len_nxt  = name_len_r + 1'b1;
            res.name_char = 1'b1;
            res.status    = RES_MORE;
          end
        end
        ST_SPACE: begin
          if (byte_r == CH_SPACE) begin
            state_nxt  = ST_VALUE_START;
            res.status = RES_MORE;
          end
        end
        ST_VALUE_START: begin
          if (!ctl) begin
            value_len_nxt   = VALUE_W'(1);
            state_nxt       = ST_VALUE;
            res.value_char  = 1'b1;
            res.value_first = 1'b1;
            res.status      = RES_MORE;
          end
        end
        ST_VALUE: begin
          if (byte_r == CH_CR) begin
            res.header_done = 1'b1;
            state_nxt       = ST_LF_ONE;
            res.status      = RES_MORE;
          end else if (!ctl && (value_len_r < limits.value_lim)) begin
            value_len_nxt  = value_len_r + 1'b1;
            res.value_char = 1'b1;
            res.status     = RES_MORE;
          end
        end
        ST_LF_ONE: begin
          if (byte_r == CH_LF) begin
            state_nxt  = ST_LINE_START;
            res.status = RES_MORE;
          end
        end
        ST_LF_TWO: begin
          // Block is complete; the machine parks here until a restart.
          if (byte_r == CH_LF) begin
            res.status = RES_OK;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LINE_START;
      name_len_r  <= '0;
      value_len_r <= '0;
    end else if (advance) begin
      state_r     <= state_nxt;
      name_len_r  <= name_len_nxt;
      value_len_r <= value_len_nxt;
    end
  end

  `HHBP_ASSERT_IMPL(a_fail_no_tags, valid_r && (res.status == RES_FAIL), ({res.name_char, res.name_first, res.value_char, res.value_first, res.header_done} == 5'b0), "failure result carries tags")
  `HHBP_ASSERT_NEXT(a_restart_clears, advance && (cmd_r == CMD_RESTART), (state_r == ST_LINE_START) && (name_len_r == '0) && (value_len_r == '0), "restart did not clear parser")
  `HHBP_ASSERT_NEXT(a_done_to_lf, advance && res.header_done, state_r == ST_LF_ONE, "header_done without move to LF wait")
  `HHBP_ASSERT_NEXT(a_value_first_len, advance && res.value_first, value_len_r == VALUE_W'(1), "value start did not set length to one")

endmodule

// File: rtl/core/hhbp_out_reg.sv
// Result register for the parser's output stream.
// Depends on hhbp_pkg; holds one result while the receiver stalls.
module hhbp_out_reg import hhbp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              res_valid,
  output logic              res_ready,
  input  result_t           res,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic [6:0]        out_tuser
);

  logic    valid_r;
  result_t res_r;

  assign res_ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_ready) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = res_r.byte_out;
  assign out_tuser  = {res_r.header_done, res_r.value_first, res_r.value_char,
                       res_r.name_first, res_r.name_char, res_r.status};

endmodule

// File: rtl/core/http_header_byte_parser.sv
// HTTP header byte parser, top level.
// Depends on hhbp_pkg, hhbp_cfg_regs, hhbp_parser and hhbp_out_reg.
//
// Usage: header bytes arrive one per request on the in_ stream. in_tuser
// is the command (0 parses in_tdata, 1 restarts at line start and clears
// both lengths). Every request yields exactly one result request on the
// out_ stream: out_tdata echoes the byte, out_tuser carries the status
// (more, complete, failure) and the name/value tags that downstream logic
// uses to assemble header strings. A failing byte leaves the parser state
// unchanged, so the next byte is judged in the same context.
// A taken byte is captured in the input register, decided combinationally
// from it, and its result is registered in the result stage. Throughput
// is one byte per cycle while the receiver does not stall; the only loop
// is the state and length counter update, closed through the decision logic.
// When the receiver stalls, the result register holds its request and the
// input register still takes one more byte, so input ready drops only once
// both stages are full. Reset (synchronous, active low) empties both
// stages, returns the parser to line start, zeroes the lengths and loads
// the limit registers with 256 and 4096. Limits are written over the APB
// port while the stream is idle; they are capped at the build-time maxima.
module http_header_byte_parser import hhbp_pkg::*; #(
  parameter int NAME_LIMIT_MAX  = NAME_LIMIT_MAX_DEF,
  parameter int VALUE_LIMIT_MAX = VALUE_LIMIT_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Input stream.
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  input  logic              in_tuser,   // [0] command
  // Result stream.
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [7:0] byte_out
  output logic [6:0]        out_tuser,  // [1:0] status, [2] name_char, [3] name_first,
                                        // [4] value_char, [5] value_first, [6] header_done
  // Configuration port.
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  limits_t limits;
  result_t res;
  logic    res_valid;
  logic    res_ready;

  hhbp_cfg_regs #(
    .NAME_LIMIT_MAX (NAME_LIMIT_MAX),
    .VALUE_LIMIT_MAX(VALUE_LIMIT_MAX)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (cfg_psel),
    .penable(cfg_penable),
    .pwrite (cfg_pwrite),
    .paddr  (cfg_paddr),
    .pwdata (cfg_pwdata),
    .prdata (cfg_prdata),
    .pready (cfg_pready),
    .limits (limits)
  );

  // Decision stage: registered byte in, next state and tags out.
  hhbp_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .limits   (limits),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_byte  (in_tdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // Result stage decouples the parser from a stalling receiver.
  hhbp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
